// ===== design/lrut_pkg.sv =====
package lrut_pkg;

  // Default sizing of the store
  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed field widths on the ports
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned EXP_W    = TIME_W + 1;

  // Staging width for zero-extending fields to stored widths of up to 64 bits
  localparam int unsigned WIDE_W = 64;

  // Request codes; code 3 is unused and ignored
  typedef enum logic [ACTION_W-1:0] {
    ACT_GET      = 2'd0,
    ACT_PUT      = 2'd1,
    ACT_CONTAINS = 2'd2
  } action_e;

  // One request item
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  write_value;
    logic [TIME_W-1:0]   now;
  } req_t;

  // One result item
  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
    logic [OCC_W-1:0]   occupancy;
  } rsp_t;

endpackage

// ===== design/lru_cache_with_ttl_top.sv =====
// Fully associative key/value store with LRU replacement and time-to-live expiry.
// One request item (get, put or contains) is accepted per clock while in_stall_o
// is low; its result item is registered in the result register, or in the skid
// register while a result still waits there. The rate is set by the combinational
// key compare over all CAPACITY entries together with the rank update of every
// entry, done in the accept cycle. A two-deep output buffer (result register plus
// skid register) lets a new item enter while a result still waits; in_stall_o rises
// only when both are full. The ttl register must be written via cfg_we_i/cfg_wdata_i
// only while no request is in flight; the block does not enforce it. Zero means
// entries never expire. Reset clears only valid bits, count, ttl and buffer flags.
module lru_cache_with_ttl_top
  import lrut_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration: ttl
  input  logic              cfg_we_i,
  input  logic [TIME_W-1:0] cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  req_t              in_item_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rsp_t              out_item_o
);

  localparam int unsigned RANK_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  // Entry storage (contents undefined until written)
  logic [KEY_BITS-1:0]   key_q   [CAPACITY];
  logic [VALUE_BITS-1:0] value_q [CAPACITY];
  logic [EXP_W-1:0]      expiry_q[CAPACITY];
  logic [RANK_W-1:0]     rank_q  [CAPACITY];
  logic [RANK_W-1:0]     rank_d  [CAPACITY];
  logic [CAPACITY-1:0]   valid_q, valid_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [TIME_W-1:0]     ttl_q;

  // Output buffer
  rsp_t out_q, skid_q, rsp;
  logic out_valid_q, skid_valid_q;

  logic in_accept, out_take;

  // Lookup and decode signals
  logic [KEY_BITS-1:0]   key_m;
  logic [VALUE_BITS-1:0] val_m;
  logic [WIDE_W-1:0]     key_wide, val_wide, rd_wide;
  logic [CAPACITY-1:0]   match, victim, free_oh, slot_oh;
  logic [CAPACITY-1:0]   key_we, val_we;
  logic [RANK_W-1:0]     rank_sel;
  logic [VALUE_BITS-1:0] value_sel;
  logic [EXP_W-1:0]      exp_sel, new_exp;
  logic                  found, expired, full;
  logic                  do_recent, do_drop, do_insert, do_update, get_hit, hit;
  logic [15:0]           cnt_wide;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_take  = out_valid_q && !out_stall_i;

  // Field masking to stored widths
  assign key_wide = WIDE_W'(in_item_i.key);
  assign val_wide = WIDE_W'(in_item_i.write_value);
  assign key_m    = key_wide[KEY_BITS-1:0];
  assign val_m    = val_wide[VALUE_BITS-1:0];

  // Parallel key compare and selection of the matching entry
  always_comb begin
    match     = '0;
    rank_sel  = '0;
    value_sel = '0;
    exp_sel   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_q[i] && (key_q[i] == key_m);
      if (match[i]) begin
        rank_sel  = rank_sel | rank_q[i];
        value_sel = value_sel | value_q[i];
        exp_sel   = exp_sel | expiry_q[i];
      end
    end
  end

  assign found   = |match;
  assign expired = (ttl_q != '0) && (exp_sel != '0) && ({1'b0, in_item_i.now} > exp_sel);
  assign full    = (count_q == CNT_W'(CAPACITY));
  assign new_exp = (ttl_q != '0) ? ({1'b0, in_item_i.now} + {1'b0, ttl_q}) : '0;

  // Victim is the valid entry of lowest recency; free slot is the lowest invalid one
  always_comb begin
    logic seen;
    seen    = 1'b0;
    victim  = '0;
    free_oh = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      victim[i]  = valid_q[i] && (rank_q[i] == RANK_W'(CAPACITY - 1));
      free_oh[i] = !valid_q[i] && !seen;
      seen       = seen || !valid_q[i];
    end
  end

  assign slot_oh = full ? victim : free_oh;

  // Request decode
  always_comb begin
    do_recent = 1'b0;
    do_drop   = 1'b0;
    do_insert = 1'b0;
    do_update = 1'b0;
    get_hit   = 1'b0;
    hit       = 1'b0;
    unique case (action_e'(in_item_i.action))
      ACT_GET: begin
        if (found && expired) begin
          do_drop = 1'b1;
        end else if (found) begin
          do_recent = 1'b1;
          get_hit   = 1'b1;
          hit       = 1'b1;
        end
      end
      ACT_PUT: begin
        if (found) begin
          do_update = 1'b1;
          do_recent = 1'b1;
        end else begin
          do_insert = 1'b1;
        end
      end
      ACT_CONTAINS: begin
        hit = found && !expired;
      end
      default: ;
    endcase
  end

  // Rank, valid and count update
  always_comb begin
    valid_d = valid_q;
    count_d = count_q;
    key_we  = '0;
    val_we  = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      rank_d[j] = rank_q[j];
      if (do_recent) begin
        if (match[j]) begin
          rank_d[j] = '0;
        end else if (valid_q[j] && (rank_q[j] < rank_sel)) begin
          rank_d[j] = rank_q[j] + RANK_W'(1);
        end
      end else if (do_drop) begin
        if (valid_q[j] && (rank_q[j] > rank_sel)) begin
          rank_d[j] = rank_q[j] - RANK_W'(1);
        end
      end else if (do_insert) begin
        if (slot_oh[j]) begin
          rank_d[j] = '0;
        end else if (valid_q[j]) begin
          rank_d[j] = rank_q[j] + RANK_W'(1);
        end
      end
    end
    if (do_drop) begin
      valid_d = valid_q & ~match;
      count_d = count_q - CNT_W'(1);
    end
    if (do_insert) begin
      valid_d = valid_q | slot_oh;
      key_we  = slot_oh;
      val_we  = slot_oh;
      if (!full) begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (do_update) begin
      val_we = match;
    end
  end

  // Result item
  assign rd_wide  = WIDE_W'(value_sel);
  assign cnt_wide = 16'(count_d);

  always_comb begin
    rsp            = '0;
    rsp.hit        = hit;
    rsp.read_value = get_hit ? rd_wide[VALUE_W-1:0] : '0;
    rsp.occupancy  = cnt_wide[OCC_W-1:0];
  end

  // Control state, ttl and output buffer flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      count_q      <= '0;
      ttl_q        <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ttl_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        valid_q <= valid_d;
        count_q <= count_d;
      end
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid_q && !out_take) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && !out_take) begin
        skid_q <= rsp;
      end else begin
        out_q <= rsp;
      end
    end
  end

  // Entry storage writes
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (in_accept && key_we[i]) begin
        key_q[i] <= key_m;
      end
      if (in_accept && val_we[i]) begin
        value_q[i]  <= val_m;
        expiry_q[i] <= new_exp;
      end
      if (in_accept) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the result register is empty");

  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) == $countones(valid_q))
    else $error("entry count differs from number of valid entries");

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i |-> $onehot0(match))
    else $error("key matched more than one entry");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && !out_valid_q) |=> out_valid_q)
    else $error("accepted item produced no result");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (int'(count_q) <= int'(CAPACITY)))
    else $error("entry count exceeds capacity");

endmodule

// ===== test/tb_lru_cache_with_ttl_top.sv =====
module tb_lru_cache_with_ttl_top;
  import lrut_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int POOL_SIZE = 24;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 190;
  localparam int STALL_LIMIT = 1000;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  // Scoreboard: mirrors the store contents and queues the expected results
  class lru_ttl_scoreboard;
    bit [TIME_W-1:0]  ttl_q;
    bit [KEY_W-1:0]   keys [CAP];
    bit [VALUE_W-1:0] vals [CAP];
    bit [EXP_W-1:0]   expiry [CAP];
    bit               live [CAP];
    int unsigned      rank [CAP];
    int unsigned      count;
    rsp_t             expected_rsp [$];
    int unsigned      errors, checked, hits, expiry_drops, evictions;

    function void set_ttl(bit [TIME_W-1:0] v);
      ttl_q = v;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    function bit is_stale(int i, bit [TIME_W-1:0] now);
      if (ttl_q == 0) return 1'b0;
      return (expiry[i] != 0) && ({1'b0, now} > expiry[i]);
    endfunction

    function int find_key(bit [KEY_W-1:0] key);
      for (int i = 0; i < CAP; i++)
        if (live[i] && keys[i] == key) return i;
      return -1;
    endfunction

    // move entry to most recent
    function void promote(int i);
      int unsigned r;
      r = rank[i];
      for (int j = 0; j < CAP; j++)
        if (live[j] && rank[j] < r) rank[j]++;
      rank[i] = 0;
    endfunction

    function void remove(int i);
      int unsigned r;
      r = rank[i];
      for (int j = 0; j < CAP; j++)
        if (live[j] && rank[j] > r) rank[j]--;
      live[i] = 1'b0;
      if (count > 0) count--;
    endfunction

    // evict least recent when full, then place in first free slot
    function void insert(bit [KEY_W-1:0] key, bit [VALUE_W-1:0] val,
                         bit [EXP_W-1:0] new_expiry);
      int          slot, victim;
      int unsigned worst;
      bit          found;
      if (count >= CAP) begin
        victim = 0;
        worst = 0;
        for (int i = 0; i < CAP; i++)
          if (live[i] && rank[i] >= worst) begin
            worst = rank[i];
            victim = i;
          end
        remove(victim);
        evictions++;
      end
      found = 1'b0;
      slot = 0;
      for (int i = 0; i < CAP; i++) begin
        if (live[i]) rank[i]++;
        else if (!found) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (!found) return;
      keys[slot] = key;
      vals[slot] = val;
      expiry[slot] = new_expiry;
      rank[slot] = 0;
      live[slot] = 1'b1;
      count++;
    endfunction

    // apply one request to the mirrored store, return its result
    function rsp_t apply_request(req_t r);
      rsp_t           res;
      int             idx;
      bit [EXP_W-1:0] new_expiry;
      res = '0;
      idx = find_key(r.key);
      case (r.action)
        ACT_GET: begin
          if (idx >= 0) begin
            if (is_stale(idx, r.now)) begin
              remove(idx);
              expiry_drops++;
            end else begin
              promote(idx);
              res.hit = 1'b1;
              res.read_value = vals[idx];
            end
          end
        end
        ACT_PUT: begin
          new_expiry = (ttl_q != 0) ? ({1'b0, r.now} + {1'b0, ttl_q}) : '0;
          if (idx >= 0) begin
            vals[idx] = r.write_value;
            expiry[idx] = new_expiry;
            promote(idx);
          end else begin
            insert(r.key, r.write_value, new_expiry);
          end
        end
        ACT_CONTAINS: begin
          if (idx >= 0 && !is_stale(idx, r.now)) res.hit = 1'b1;
        end
        default: ;
      endcase
      res.occupancy = OCC_W'(count);
      if (res.hit) hits++;
      return res;
    endfunction

    // queue the expected result at the tail
    function void note_request(req_t r);
      expected_rsp = {expected_rsp, apply_request(r)};
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected result item hit=%0b value=%h occ=%0d",
                 $time, got.hit, got.read_value, got.occupancy);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (got.hit !== want.hit) begin
        $display("%0t: hit mismatch, expected %0b actual %0b", $time, want.hit, got.hit);
        errors++;
      end
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch, expected %h actual %h",
                 $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.occupancy !== want.occupancy) begin
        $display("%0t: occupancy mismatch, expected %0d actual %0d",
                 $time, want.occupancy, got.occupancy);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [TIME_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  req_t              in_item_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  rsp_t              out_item_o;

  lru_cache_with_ttl_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #10 clk_i = ~clk_i;

  lru_ttl_scoreboard sb = new();

  bit [KEY_W-1:0]  key_pool [POOL_SIZE];
  bit [TIME_W-1:0] tnow;
  bit              tx_quiet = 1'b0;
  bit              rx_quiet = 1'b0;
  int              hold_cycles = 0;
  int              sent = 0;

  function automatic req_t mk_req(logic [ACTION_W-1:0] action, logic [KEY_W-1:0] key,
                                  logic [VALUE_W-1:0] val, logic [TIME_W-1:0] now);
    req_t r;
    r.action = action;
    r.key = key;
    r.write_value = val;
    r.now = now;
    return r;
  endfunction

  // mostly pool keys on an advancing clock; some full-range keys and times
  function automatic req_t random_request();
    req_t r;
    int   w;
    w = $urandom_range(0, 99);
    if (w < 38) r.action = ACT_GET;
    else if (w < 73) r.action = ACT_PUT;
    else if (w < 97) r.action = ACT_CONTAINS;
    else r.action = ACT_UNUSED;
    r.key = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom)
                                        : key_pool[$urandom_range(0, POOL_SIZE - 1)];
    r.write_value = $urandom;
    tnow = tnow + $urandom_range(0, 3);
    r.now = ($urandom_range(0, 49) == 0) ? TIME_W'($urandom) : tnow;
    return r;
  endfunction

  // offer one item, return at the edge that accepts it
  task automatic send_item(req_t r);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    sent++;
  endtask

  // drop valid and wait for all results plus the pipeline tail
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_ttl(logic [TIME_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_ttl(v);
    cfg_we_i <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      n = rx_quiet ? 0 : $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_response(out_item_o);
    end
  end

  // watchdog: too long without any item moving
  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // main sequence
  initial begin
    bit [TIME_W-1:0] ttl_plan [PHASES];
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    ttl_plan[0] = '0;
    ttl_plan[1] = 32'd1;
    ttl_plan[2] = $urandom_range(2, 40);
    ttl_plan[3] = '1;
    ttl_plan[4] = $urandom_range(2, 40);
    ttl_plan[5] = $urandom;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no expiry: extremes, every action, ignored code, update in place
    write_ttl('0);
    send_item(mk_req(ACT_PUT, '0, '0, '0));
    send_item(mk_req(ACT_PUT, '1, '1, '1));
    send_item(mk_req(ACT_GET, '0, '1, '0));
    send_item(mk_req(ACT_GET, '1, '0, '1));
    send_item(mk_req(ACT_CONTAINS, '1, '0, '0));
    send_item(mk_req(ACT_GET, 32'h1234_5678, '0, 32'd7));
    send_item(mk_req(ACT_CONTAINS, 32'h1234_5678, '0, 32'd7));
    send_item(mk_req(ACT_UNUSED, '0, '1, '1));
    send_item(mk_req(ACT_PUT, '0, 32'hA5A5_A5A5, 32'd9));
    send_item(mk_req(ACT_GET, '0, '0, 32'd9));
    drain();

    // short lifetime: boundary, contains keeps a stale entry, get drops it
    write_ttl(32'd5);
    send_item(mk_req(ACT_PUT, 32'h100, 32'd1, 32'd100));
    send_item(mk_req(ACT_CONTAINS, 32'h100, '0, 32'd105));
    send_item(mk_req(ACT_CONTAINS, 32'h100, '0, 32'd106));
    send_item(mk_req(ACT_GET, '0, '0, '1));
    send_item(mk_req(ACT_GET, 32'h100, '0, 32'd106));
    send_item(mk_req(ACT_GET, 32'h100, '0, 32'd50));
    drain();

    // maximum lifetime: expiry sum needs the 33rd bit
    write_ttl('1);
    send_item(mk_req(ACT_PUT, 32'h200, 32'h5A5A_5A5A, '1));
    send_item(mk_req(ACT_GET, 32'h200, '0, '1));
    send_item(mk_req(ACT_CONTAINS, 32'h200, '0, '0));
    send_item(mk_req(ACT_PUT, 32'h200, 32'h0F0F_0F0F, 32'd1));
    drain();

    // random phases over several lifetimes
    for (int ph = 0; ph < PHASES; ph++) begin
      write_ttl(ttl_plan[ph]);
      tnow = (ph == 4) ? 32'hFFFF_FF80 : TIME_W'($urandom);
      if (ph == 2) hold_cycles = 80;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) begin
          tx_quiet = (ph == 2) || ($urandom_range(0, 3) == 0);
          rx_quiet = ($urandom_range(0, 3) == 0);
        end
        if (ph == 3 && k == PHASE_ITEMS / 2) drain();
        send_item(random_request());
      end
      drain();
    end

    $display("Sent %0d requests over %0d lifetime settings; %0d results checked",
             sent, PHASES + 3, sb.checked);
    $display("Hits %0d, stale entries removed by get %0d, evictions %0d",
             sb.hits, sb.expiry_drops, sb.evictions);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
